// ===== hw/rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types for the shift-subtract divider: controller states and the
// command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ssd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } ssd_state_t;

  // Commands from controller to datapath, at most one high per cycle
  typedef struct packed {
    logic load;  // capture operands, take magnitudes
    logic step;  // resolve one quotient bit
    logic fix;   // apply sign and error handling, update result registers
  } ssd_cmd_t;

endpackage

// ===== hw/rtl/ssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssd_ctrl
// Controller: accepts a request, sequences one subtract step per quotient
// bit, then the fix-up step, and raises the result strobe.
// ----------------------------------------------------------------------------
module ssd_ctrl #(
  parameter int DATA_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output ssd_pkg::ssd_cmd_t cmd_out
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  ssd_pkg::ssd_state_t state;
  ssd_pkg::ssd_state_t state_next;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssd_pkg::ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= cmd_out.fix;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd_out.load = 1'b0;
    cmd_out.step = 1'b0;
    cmd_out.fix  = 1'b0;
    case (state)
      ssd_pkg::ST_IDLE: begin
        if (start) begin
          cmd_out.load = 1'b1;
          cnt_next     = '0;
          state_next   = ssd_pkg::ST_RUN;
        end
      end
      ssd_pkg::ST_RUN: begin
        cmd_out.step = 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = ssd_pkg::ST_FIX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ssd_pkg::ST_FIX: begin
        cmd_out.fix = 1'b1;
        state_next  = ssd_pkg::ST_IDLE;
      end
      default: begin
        state_next = ssd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ssd_pkg::ST_IDLE);

endmodule

// ===== hw/rtl/ssd_dp.sv =====
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath: operand magnitudes, restoring shift-subtract array of one
// stage, sign fix-up and the result registers.
// ----------------------------------------------------------------------------
module ssd_dp #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  ssd_pkg::ssd_cmd_t     cmd_in,
  input  logic                  cmd,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic                  div_by_zero
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] rem;
  logic [W-1:0] quo;   // dividend bits shift out the top, quotient bits in below
  logic [W-1:0] dsr;
  logic         neg;
  logic         dbz;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W:0]   rem_sh;
  logic [W+1:0] diff;
  logic         fits;

  always_comb begin
    mag_a  = (cmd && dividend[W-1]) ? (~dividend + 1'b1) : dividend;
    mag_b  = (cmd && divisor[W-1])  ? (~divisor + 1'b1)  : divisor;
    rem_sh = {rem, quo[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    fits   = !diff[W+1];
  end

  always_ff @(posedge clk) begin
    if (cmd_in.load) begin
      rem <= '0;
      quo <= mag_a;
      dsr <= mag_b;
      neg <= cmd && (dividend[W-1] ^ divisor[W-1]);
      dbz <= (divisor == '0);
    end else if (cmd_in.step) begin
      rem <= fits ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
    // A zero divisor already leaves all ones in quo and the dividend magnitude in rem
    if (cmd_in.fix) begin
      quotient    <= (neg && !dbz) ? (~quo + 1'b1) : quo;
      remainder   <= rem;
      div_by_zero <= dbz;
    end
  end

endmodule

// ===== hw/rtl/shift_subtract_divider.sv =====
// ----------------------------------------------------------------------------
// shift_subtract_divider
// Restoring divider, unsigned or signed, with divide-by-zero flag.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. done
// rises after the subtract steps and the sign fix-up, registered from the
// fix-up state, and marks quotient, remainder and div_by_zero for exactly
// one cycle; the word must be captured at the edge that ends that cycle,
// since the block cannot be held off. busy stays high after a request
// through DATA_WIDTH subtract steps and one sign fix-up and drops as done
// rises. The next request is taken at the earliest on the edge that ends
// the done cycle. The single subtract-compare stage resolves one quotient
// bit per cycle. In signed mode the quotient is negated when the operand
// signs differ and the divisor is nonzero, and the remainder is that of
// the magnitudes. A zero divisor gives an all-ones quotient, the dividend
// magnitude as remainder and div_by_zero high.
// ----------------------------------------------------------------------------
module shift_subtract_divider #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic                  div_by_zero
);

  ssd_pkg::ssd_cmd_t dp_cmd;

  ssd_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .cmd_out (dp_cmd)
  );

  ssd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd_in      (dp_cmd),
    .cmd         (cmd),
    .dividend    (dividend),
    .divisor     (divisor),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_by_zero (div_by_zero)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_dbz_ones: assert property (@(posedge clk) disable iff (rst)
    (done && div_by_zero) |-> (&quotient))
    else $error("divide by zero without all-ones quotient");
`endif

endmodule
